// ----- rtl/ptpi_pkg.sv -----
// ptpi_pkg: shared types and constants for the peak/trough phase interpolator
// used by every module under rtl/, depends on nothing
package ptpi_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_EVENTS  = 512;
  localparam int SAMPLE_W    = 16;
  localparam int PHASE_W     = 16;
  localparam int IDX_W       = 10;                 // sample position
  localparam int CNT_W       = IDX_W + 1;          // sample count, holds MAX_SAMPLES
  localparam int EVT_AW      = $clog2(MAX_EVENTS); // event store address
  localparam int EVT_CW      = EVT_AW + 1;         // event count, holds MAX_EVENTS
  localparam int DIV_CW      = $clog2(PHASE_W);    // divider step counter

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [PHASE_W-1:0] PHASE_HALF = {1'b1, {(PHASE_W-1){1'b0}}};

  typedef struct packed {
    logic                       kind;   // 0 load sample, 1 drain request
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [PHASE_W-1:0] phase;
    logic                      phase_valid;
    logic                      last_res;
  } out_t;

  // one classified command from the front to the back
  typedef struct packed {
    logic              wr;     // record an event
    logic [EVT_AW-1:0] addr;   // event slot
    logic [IDX_W-1:0]  pos;    // event position, or drain position
    logic              peak;
    logic              start;  // begin draining
    logic [EVT_CW-1:0] cnt;    // events recorded at start
    logic              drain;  // produce one phase
    logic              fin;    // final sample of the series
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic             peak;
  } evt_t;

endpackage

// ----- rtl/ptpi_front.sv -----
// ptpi_front: accepts requests, tracks load/drain mode and detects events
// depends on ptpi_pkg
module ptpi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ptpi_pkg::in_t   in_data_i,
  output logic            in_stall_o,
  input  logic            full_i,
  output logic            push_o,
  output ptpi_pkg::cmd_t  cmd_o
);

  logic signed [ptpi_pkg::SAMPLE_W-1:0] older_q, older_d, prev_q, prev_d;
  logic [ptpi_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ptpi_pkg::EVT_CW-1:0] evcnt_q, evcnt_d;
  logic [ptpi_pkg::IDX_W-1:0]  dpos_q, dpos_d;
  logic                        draining_q, draining_d;
  logic                        accept, pk, tr, fin;
  ptpi_pkg::cmd_t              cmd;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign pk  = (prev_q > older_q) && (prev_q > in_data_i.sample);
  assign tr  = (prev_q < older_q) && (prev_q < in_data_i.sample);
  assign fin = ({1'b0, dpos_q} + ptpi_pkg::CNT_W'(1)) >= count_q;

  always_comb begin
    older_d    = older_q;
    prev_d     = prev_q;
    count_d    = count_q;
    evcnt_d    = evcnt_q;
    dpos_d     = dpos_q;
    draining_d = draining_q;
    cmd        = '0;
    cmd.addr   = evcnt_q[ptpi_pkg::EVT_AW-1:0];
    cmd.pos    = dpos_q;
    cmd.peak   = pk;
    cmd.fin    = fin;
    if (accept) begin
      if (!in_data_i.kind && !draining_q) begin
        if (count_q < ptpi_pkg::CNT_W'(ptpi_pkg::MAX_SAMPLES)) begin
          if ((count_q >= ptpi_pkg::CNT_W'(2)) && (pk || tr) &&
              (evcnt_q < ptpi_pkg::EVT_CW'(ptpi_pkg::MAX_EVENTS))) begin
            cmd.wr  = 1'b1;
            cmd.pos = ptpi_pkg::IDX_W'(count_q - ptpi_pkg::CNT_W'(1));
            evcnt_d = evcnt_q + ptpi_pkg::EVT_CW'(1);
          end
          older_d = prev_q;
          prev_d  = in_data_i.sample;
          count_d = count_q + ptpi_pkg::CNT_W'(1);
        end
        if (in_data_i.last) begin
          draining_d = 1'b1;
          dpos_d     = '0;
          cmd.start  = 1'b1;
          cmd.cnt    = evcnt_d;
        end
      end else if (in_data_i.kind && draining_q) begin
        cmd.drain = 1'b1;
        if (fin) begin
          older_d    = '0;
          prev_d     = '0;
          count_d    = '0;
          evcnt_d    = '0;
          dpos_d     = '0;
          draining_d = 1'b0;
        end else begin
          dpos_d = dpos_q + ptpi_pkg::IDX_W'(1);
        end
      end
    end
  end

  assign push_o = accept && (cmd.wr || cmd.start || cmd.drain);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q    <= '0;
      prev_q     <= '0;
      count_q    <= '0;
      evcnt_q    <= '0;
      dpos_q     <= '0;
      draining_q <= 1'b0;
    end else begin
      older_q    <= older_d;
      prev_q     <= prev_d;
      count_q    <= count_d;
      evcnt_q    <= evcnt_d;
      dpos_q     <= dpos_d;
      draining_q <= draining_d;
    end
  end

endmodule

// ----- rtl/ptpi_fifo.sv -----
// ptpi_fifo: short command queue between front and back
// depends on ptpi_pkg
module ptpi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptpi_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output ptpi_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  ptpi_pkg::cmd_t                 mem_q [ptpi_pkg::FIFO_DEPTH];
  logic [ptpi_pkg::FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [ptpi_pkg::FIFO_AW:0]     fill_q, fill_d;
  logic                           do_push, do_pop;

  assign full_o  = fill_q == (ptpi_pkg::FIFO_AW+1)'(ptpi_pkg::FIFO_DEPTH);
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    fill_d = fill_q;
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + (ptpi_pkg::FIFO_AW+1)'(1);
      2'b01:   fill_d = fill_q - (ptpi_pkg::FIFO_AW+1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + ptpi_pkg::FIFO_AW'(1);
      if (do_pop)  rptr_q <= rptr_q + ptpi_pkg::FIFO_AW'(1);
      fill_q <= fill_d;
    end
  end

endmodule

// ----- rtl/ptpi_div.sv -----
// ptpi_div: bit-serial restoring divider, half turn over event distance
// depends on ptpi_pkg
module ptpi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ptpi_pkg::IDX_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [ptpi_pkg::PHASE_W-1:0] quot_o
);

  logic                          busy_q, done_q;
  logic [ptpi_pkg::DIV_CW-1:0]   step_q;
  logic [ptpi_pkg::IDX_W-1:0]    rem_q, den_q, rem_d;
  logic [ptpi_pkg::PHASE_W-1:0]  num_q;
  logic [ptpi_pkg::IDX_W:0]      trial, diff;
  logic                          ge;

  assign trial = {rem_q, num_q[ptpi_pkg::PHASE_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[ptpi_pkg::IDX_W-1:0] : trial[ptpi_pkg::IDX_W-1:0];

  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= ptpi_pkg::PHASE_HALF;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[ptpi_pkg::PHASE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + ptpi_pkg::DIV_CW'(1);
        if (step_q == ptpi_pkg::DIV_CW'(ptpi_pkg::PHASE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ptpi_back.sv -----
// ptpi_back: event store, phase accumulation and output register
// depends on ptpi_pkg and ptpi_div
module ptpi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ptpi_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output ptpi_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_CUR   = 3'd2;
  localparam logic [2:0] ST_NEXT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  ptpi_pkg::evt_t                mem [ptpi_pkg::MAX_EVENTS];
  ptpi_pkg::evt_t                rdata_q, cur_q, cur_d, wdata;
  logic [ptpi_pkg::EVT_AW-1:0]   raddr;
  logic                          mem_we;

  logic [2:0]                    state_q, state_d;
  logic [ptpi_pkg::EVT_CW-1:0]   cnt_q, cnt_d, ptr_q, ptr_d, ptr_n;
  logic [ptpi_pkg::PHASE_W-1:0]  acc_q, acc_d, acc_n, step_q, step_d;
  logic                          out_valid_q, out_valid_d, slot_free, hit, valid;
  ptpi_pkg::out_t                out_q, out_d;

  logic                          div_start, div_done;
  logic [ptpi_pkg::IDX_W-1:0]    divisor;
  logic [ptpi_pkg::PHASE_W-1:0]  quot;

  ptpi_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign slot_free = !out_valid_q || !out_stall_i;
  assign wdata     = '{pos: cmd_i.pos, peak: cmd_i.peak};
  assign hit       = (ptr_q < cnt_q) && (cur_q.pos == cmd_i.pos);
  assign divisor   = rdata_q.pos - cur_q.pos;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    acc_d       = acc_q;
    step_d      = step_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    raddr       = ptr_q[ptpi_pkg::EVT_AW-1:0];
    div_start   = 1'b0;
    ptr_n       = ptr_q;
    acc_n       = acc_q + step_q;
    valid       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i && slot_free) begin
          pop_o = 1'b1;
          if (cmd_i.wr) begin
            mem_we = 1'b1;
          end
          if (cmd_i.start) begin
            cnt_d   = cmd_i.cnt;
            ptr_d   = '0;
            acc_d   = '0;
            step_d  = '0;
            state_d = ST_FETCH;
          end
          if (cmd_i.drain) begin
            // event sample: snap to 0 or -pi and fetch the following event
            if (hit) begin
              acc_n = cur_q.peak ? '0 : ptpi_pkg::PHASE_HALF;
              ptr_n = ptr_q + ptpi_pkg::EVT_CW'(1);
              if (ptr_n < cnt_q) begin
                raddr   = ptr_n[ptpi_pkg::EVT_AW-1:0];
                state_d = ST_NEXT;
              end else begin
                step_d = '0;
              end
            end
            valid       = (ptr_n != '0) && (ptr_n < cnt_q);
            ptr_d       = ptr_n;
            acc_d       = acc_n;
            out_valid_d = 1'b1;
            out_d.index       = cmd_i.pos;
            out_d.phase       = valid ? acc_n : '0;
            out_d.phase_valid = valid;
            out_d.last_res    = cmd_i.fin;
          end
        end
      end
      ST_FETCH: begin
        raddr   = '0;
        state_d = ST_CUR;
      end
      ST_CUR: begin
        cur_d   = rdata_q;
        state_d = ST_IDLE;
      end
      ST_NEXT: begin
        cur_d     = rdata_q;
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          step_d  = quot;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.addr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      acc_q       <= acc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/peak_trough_phase_interpolator.sv -----
// peak_trough_phase_interpolator: top level, front + command queue + back
// path: a phase request is queued, then registered at the back's output
// throughput: one request per cycle into a 4-deep queue while it is not full;
//   the back takes one per cycle while idle with a free output, and pauses at
//   drain start and at each event sample (store read, 16-step serial divider)
// reset: asynchronous active low, clears counters and modes; event store unreset
module peak_trough_phase_interpolator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  ptpi_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output ptpi_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  // front classifies each request: sample load, event record, drain start,
  // or phase request; requests that do not fit the current mode are dropped
  logic           push, full, pop, empty;
  ptpi_pkg::cmd_t cmd_in, cmd_out;

  ptpi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // queue lets the front keep taking requests while the back divides
  ptpi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  // back owns the event store and the phase accumulator, and holds the result in
  // an output register; a stalled output holds the back, so the queue fills up
  ptpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
